// ----- hdl/amsgrad_weight_update_core_assert.svh -----
// Assertion macros used by the checker of the weight update core.
`ifndef AMSGRAD_WEIGHT_UPDATE_CORE_ASSERT_SVH
`define AMSGRAD_WEIGHT_UPDATE_CORE_ASSERT_SVH

// Checked on every rising edge outside reset.
`define AWU_ASSERT(name, prop) \
   name: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("weight update core assertion failed");

// Checked on every rising edge, reset included.
`define AWU_ASSERT_ALWAYS(name, prop) \
   name: assert property (@(posedge clock) prop) \
      else $error("weight update core assertion failed");

`endif

// ----- hdl/awu_pkg.sv -----
package awu_pkg;

   localparam logic [24:0] ONE_Q24 = 25'h100_0000;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_LEARNING_RATE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_DECAY    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SECOND_DECAY   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_STABILITY_TERM = 2'd3;

   localparam logic [24:0] LEARNING_RATE_RESET  = 25'd16777;
   localparam logic [24:0] FIRST_DECAY_RESET    = 25'd15099494;
   localparam logic [24:0] SECOND_DECAY_RESET   = 25'd16760439;
   localparam logic [31:0] STABILITY_TERM_RESET = 32'd43;

   localparam logic [31:0] SAT_POS = 32'h7FFF_FFFF;
   localparam logic [31:0] SAT_NEG = 32'h8000_0000;

   // Square root steps (two radicand bits each), quotient bits and divisor width.
   localparam int SQRT_STEPS = 32;
   localparam int QUO_BITS   = 33;
   localparam int DEN_W      = 49;

   typedef struct packed {
      logic [9:0]         element_index;
      logic signed [31:0] gradient;
      logic               first_use;
   } req_type;

   typedef struct packed {
      logic signed [31:0] delta_weight;
      logic [9:0]         element_tag;
      logic               overflowed;
   } rsp_type;

   function automatic logic [24:0] clamp_q24(input logic [24:0] x);
      return (x > ONE_Q24) ? ONE_Q24 : x;
   endfunction

endpackage

// ----- hdl/amsgrad_weight_update_core.sv -----
// Throughput: one beat per cycle while the output buffer has room; a request for
// an element that is still in the four read-modify-write stages waits until the
// earlier write-back has been done. The square root (32 stages) and the divider
// (33 stages) are fully pipelined. Synchronous reset clears the control state and
// loads the register defaults; moment memories hold no reset value.
module amsgrad_weight_update_core #(
   parameter int DEPTH      = 1024,
   parameter int GRAD_WIDTH = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  awu_pkg::req_type                    req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output awu_pkg::rsp_type                    rsp_data,
   input  logic                                csr_we,
   input  logic [awu_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [awu_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int WW  = (AW > 10) ? AW : 10;
   localparam int GS  = 32 - GRAD_WIDTH;
   localparam int NSQ = awu_pkg::SQRT_STEPS;
   localparam int NQ  = awu_pkg::QUO_BITS;
   localparam int DW  = awu_pkg::DEN_W;
   localparam int SW  = awu_pkg::DEN_W + awu_pkg::QUO_BITS;

   // Configuration; the three Q24 factors are stored already clamped to one.
   logic [24:0] lr_ff, b1_ff, b2_ff;
   logic [31:0] eps_ff;
   logic [24:0] nb1, nb2;

   always_ff @(posedge clock) begin
      if (reset) begin
         lr_ff  <= awu_pkg::LEARNING_RATE_RESET;
         b1_ff  <= awu_pkg::FIRST_DECAY_RESET;
         b2_ff  <= awu_pkg::SECOND_DECAY_RESET;
         eps_ff <= awu_pkg::STABILITY_TERM_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            awu_pkg::CSR_LEARNING_RATE:  lr_ff  <= awu_pkg::clamp_q24(csr_wdata[24:0]);
            awu_pkg::CSR_FIRST_DECAY:    b1_ff  <= awu_pkg::clamp_q24(csr_wdata[24:0]);
            awu_pkg::CSR_SECOND_DECAY:   b2_ff  <= awu_pkg::clamp_q24(csr_wdata[24:0]);
            awu_pkg::CSR_STABILITY_TERM: eps_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign nb1 = awu_pkg::ONE_Q24 - b1_ff;
   assign nb2 = awu_pkg::ONE_Q24 - b2_ff;

   // Index wrap by conditional subtraction of DEPTH scaled by powers of two.
   logic [WW-1:0]      wrap;
   logic [AW-1:0]      req_addr;
   logic signed [31:0] g_in;

   always_comb begin
      wrap = WW'(req_data.element_index);
      for (int k = 9; k >= 0; k--) begin
         if ((DEPTH << k) < 1024) begin
            if (wrap >= WW'(DEPTH << k)) begin
               wrap = wrap - WW'(DEPTH << k);
            end
         end
      end
   end

   assign req_addr = wrap[AW-1:0];
   assign g_in     = (req_data.gradient <<< GS) >>> GS;

   // Pipeline control: every stage moves while the output buffer has room.
   logic [1:0] ob_cnt_ff, ob_cnt_in;
   logic       adv, hazard, accept, push, pop;

   logic p1_v_ff, p2_v_ff, p3_v_ff, p4_v_ff;
   logic [AW-1:0] p1_addr_ff, p2_addr_ff, p3_addr_ff, p4_addr_ff;

   assign adv    = (ob_cnt_ff != 2'd2);
   assign hazard = (p1_v_ff && p1_addr_ff == req_addr) || (p2_v_ff && p2_addr_ff == req_addr)
                || (p3_v_ff && p3_addr_ff == req_addr) || (p4_v_ff && p4_addr_ff == req_addr);
   assign req_ready = adv && !hazard;
   assign accept    = req_valid && req_ready;

   // Moment memories.
   logic signed [31:0] m_mem_ff  [DEPTH];
   logic [63:0]        v_mem_ff  [DEPTH];
   logic [63:0]        vh_mem_ff [DEPTH];
   logic signed [31:0] rd_m_ff;
   logic [63:0]        rd_v_ff, rd_vh_ff;

   logic signed [31:0] p4_m_ff;
   logic [63:0]        v_new, vh_new;

   always_ff @(posedge clock) begin
      if (adv) begin
         rd_m_ff  <= m_mem_ff[req_addr];
         rd_v_ff  <= v_mem_ff[req_addr];
         rd_vh_ff <= vh_mem_ff[req_addr];
      end
      if (adv && p4_v_ff) begin
         m_mem_ff[p4_addr_ff]  <= p4_m_ff;
         v_mem_ff[p4_addr_ff]  <= v_new;
         vh_mem_ff[p4_addr_ff] <= vh_new;
      end
   end

   // Stage 1: read data arrives; clear on first use and form the products.
   logic [9:0]         p1_tag_ff;
   logic signed [31:0] p1_g_ff;
   logic               p1_clr_ff;
   logic signed [31:0] m0;
   logic [63:0]        v0, vh0;
   logic signed [63:0] gsq_s;

   assign m0    = p1_clr_ff ? 32'sd0 : rd_m_ff;
   assign v0    = p1_clr_ff ? 64'd0 : rd_v_ff;
   assign vh0   = p1_clr_ff ? 64'd0 : rd_vh_ff;
   assign gsq_s = p1_g_ff * p1_g_ff;

   logic [9:0]         p2_tag_ff;
   logic signed [57:0] p2_pm_ff, p2_pg_ff, p2_pm_in, p2_pg_in;
   logic [63:0]        p2_gsq_ff, p2_vh_ff;
   logic [40:0]        p2_bvh_ff, p2_bvh_in;
   logic [48:0]        p2_bvm_ff, p2_bvl_ff, p2_bvm_in, p2_bvl_in;

   assign p2_pm_in  = $signed({1'b0, b1_ff}) * m0;
   assign p2_pg_in  = $signed({1'b0, nb1}) * p1_g_ff;
   assign p2_bvh_in = b2_ff * v0[63:48];
   assign p2_bvm_in = b2_ff * v0[47:24];
   assign p2_bvl_in = b2_ff * v0[23:0];

   // Stage 2: first moment and the gradient-square products.
   logic signed [57:0] msum;
   logic [9:0]         p3_tag_ff;
   logic signed [31:0] p3_m_ff;
   logic [63:0]        p3_vh_ff;
   logic [40:0]        p3_bvh_ff, p3_cgh_ff, p3_cgh_in;
   logic [48:0]        p3_bvm_ff, p3_bvl_ff, p3_cgm_ff, p3_cgl_ff, p3_cgm_in, p3_cgl_in;

   assign msum      = p2_pm_ff + p2_pg_ff;
   assign p3_cgh_in = nb2 * p2_gsq_ff[63:48];
   assign p3_cgm_in = nb2 * p2_gsq_ff[47:24];
   assign p3_cgl_in = nb2 * p2_gsq_ff[23:0];

   // Stage 3: high and low partial sums of the second moment.
   logic [9:0]  p4_tag_ff;
   logic [63:0] p4_hi_ff, p4_hi_in, p4_vh_ff;
   logic [49:0] p4_lo_ff, p4_lo_in;

   assign p4_hi_in = (64'(p3_bvh_ff) << 24) + 64'(p3_bvm_ff)
                   + (64'(p3_cgh_ff) << 24) + 64'(p3_cgm_ff);
   assign p4_lo_in = 50'(p3_bvl_ff) + 50'(p3_cgl_ff);

   // Stage 4: second moment, running maximum and write-back.
   assign v_new  = p4_hi_ff + 64'(p4_lo_ff[49:24]);
   assign vh_new = (v_new > p4_vh_ff) ? v_new : p4_vh_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         p1_addr_ff <= req_addr;
         p1_tag_ff  <= req_data.element_index;
         p1_g_ff    <= g_in;
         p1_clr_ff  <= req_data.first_use;
         p2_addr_ff <= p1_addr_ff;
         p2_tag_ff  <= p1_tag_ff;
         p2_pm_ff   <= p2_pm_in;
         p2_pg_ff   <= p2_pg_in;
         p2_gsq_ff  <= unsigned'(gsq_s);
         p2_vh_ff   <= vh0;
         p2_bvh_ff  <= p2_bvh_in;
         p2_bvm_ff  <= p2_bvm_in;
         p2_bvl_ff  <= p2_bvl_in;
         p3_addr_ff <= p2_addr_ff;
         p3_tag_ff  <= p2_tag_ff;
         p3_m_ff    <= msum[55:24];
         p3_vh_ff   <= p2_vh_ff;
         p3_bvh_ff  <= p2_bvh_ff;
         p3_bvm_ff  <= p2_bvm_ff;
         p3_bvl_ff  <= p2_bvl_ff;
         p3_cgh_ff  <= p3_cgh_in;
         p3_cgm_ff  <= p3_cgm_in;
         p3_cgl_ff  <= p3_cgl_in;
         p4_addr_ff <= p3_addr_ff;
         p4_tag_ff  <= p3_tag_ff;
         p4_m_ff    <= p3_m_ff;
         p4_vh_ff   <= p3_vh_ff;
         p4_hi_ff   <= p4_hi_in;
         p4_lo_ff   <= p4_lo_in;
      end
   end

   // Integer square root of the running maximum, two radicand bits a stage.
   logic          sq_v_ff   [NSQ+1];
   logic [63:0]   sq_x_ff   [NSQ+1];
   logic [63:0]   sq_r_ff   [NSQ+1];
   logic [9:0]    sq_tag_ff [NSQ+1];
   logic          sq_neg_ff [NSQ+1];
   logic [31:0]   sq_mag_ff [NSQ+1];
   logic [63:0]   sq_x_in   [NSQ];
   logic [63:0]   sq_r_in   [NSQ];

   for (genvar k = 0; k < NSQ; k++) begin : g_sqrt
      localparam logic [63:0] SQ_BIT = 64'd1 << (62 - 2 * k);
      logic [63:0] trial;
      logic        fits;
      assign trial      = sq_r_ff[k] + SQ_BIT;
      assign fits       = (sq_x_ff[k] >= trial);
      assign sq_x_in[k] = fits ? sq_x_ff[k] - trial : sq_x_ff[k];
      assign sq_r_in[k] = fits ? (sq_r_ff[k] >> 1) + SQ_BIT : sq_r_ff[k] >> 1;
   end

   // Denominator and numerator.
   logic [56:0]   num_prod;
   logic          dn_v_ff;
   logic [9:0]    dn_tag_ff;
   logic          dn_neg_ff;
   logic [63:0]   dn_num_ff;
   logic [DW-1:0] dn_den_ff;

   assign num_prod = lr_ff * sq_mag_ff[NSQ];

   // Restoring divider, one quotient bit a stage.
   logic          dv_v_ff    [NQ+1];
   logic [9:0]    dv_tag_ff  [NQ+1];
   logic          dv_neg_ff  [NQ+1];
   logic          dv_zero_ff [NQ+1];
   logic          dv_big_ff  [NQ+1];
   logic [63:0]   dv_rem_ff  [NQ+1];
   logic [DW-1:0] dv_den_ff  [NQ+1];
   logic [NQ-1:0] dv_q_ff    [NQ+1];
   logic [63:0]   dv_rem_in  [NQ];
   logic [NQ-1:0] dv_q_in    [NQ];

   for (genvar j = 0; j < NQ; j++) begin : g_div
      localparam int SH = NQ - 1 - j;
      logic [SW-1:0] sub;
      logic          ge;
      assign sub          = SW'(dv_den_ff[j]) << SH;
      assign ge           = (SW'(dv_rem_ff[j]) >= sub);
      assign dv_rem_in[j] = ge ? dv_rem_ff[j] - sub[63:0] : dv_rem_ff[j];
      assign dv_q_in[j]   = dv_q_ff[j] | (NQ'(ge) << SH);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sq_x_ff[0]   <= vh_new;
         sq_r_ff[0]   <= 64'd0;
         sq_tag_ff[0] <= p4_tag_ff;
         sq_neg_ff[0] <= p4_m_ff[31];
         sq_mag_ff[0] <= p4_m_ff[31] ? unsigned'(-p4_m_ff) : unsigned'(p4_m_ff);
         for (int k = 0; k < NSQ; k++) begin
            sq_x_ff[k+1]   <= sq_x_in[k];
            sq_r_ff[k+1]   <= sq_r_in[k];
            sq_tag_ff[k+1] <= sq_tag_ff[k];
            sq_neg_ff[k+1] <= sq_neg_ff[k];
            sq_mag_ff[k+1] <= sq_mag_ff[k];
         end
         dn_tag_ff <= sq_tag_ff[NSQ];
         dn_neg_ff <= sq_neg_ff[NSQ];
         dn_num_ff <= {num_prod[55:0], 8'd0};
         dn_den_ff <= (DW'(sq_r_ff[NSQ][31:0]) << 16) + DW'(eps_ff);
         dv_tag_ff[0]  <= dn_tag_ff;
         dv_neg_ff[0]  <= dn_neg_ff;
         dv_zero_ff[0] <= (dn_den_ff == '0);
         dv_big_ff[0]  <= (SW'(dn_num_ff) >= (SW'(dn_den_ff) << NQ));
         dv_rem_ff[0]  <= dn_num_ff;
         dv_den_ff[0]  <= dn_den_ff;
         dv_q_ff[0]    <= '0;
         for (int j = 0; j < NQ; j++) begin
            dv_tag_ff[j+1]  <= dv_tag_ff[j];
            dv_neg_ff[j+1]  <= dv_neg_ff[j];
            dv_zero_ff[j+1] <= dv_zero_ff[j];
            dv_big_ff[j+1]  <= dv_big_ff[j];
            dv_rem_ff[j+1]  <= dv_rem_in[j];
            dv_den_ff[j+1]  <= dv_den_ff[j];
            dv_q_ff[j+1]    <= dv_q_in[j];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_v_ff <= 1'b0;
         p2_v_ff <= 1'b0;
         p3_v_ff <= 1'b0;
         p4_v_ff <= 1'b0;
         dn_v_ff <= 1'b0;
         for (int k = 0; k <= NSQ; k++) begin
            sq_v_ff[k] <= 1'b0;
         end
         for (int j = 0; j <= NQ; j++) begin
            dv_v_ff[j] <= 1'b0;
         end
      end else if (adv) begin
         p1_v_ff    <= accept;
         p2_v_ff    <= p1_v_ff;
         p3_v_ff    <= p2_v_ff;
         p4_v_ff    <= p3_v_ff;
         sq_v_ff[0] <= p4_v_ff;
         for (int k = 0; k < NSQ; k++) begin
            sq_v_ff[k+1] <= sq_v_ff[k];
         end
         dn_v_ff    <= sq_v_ff[NSQ];
         dv_v_ff[0] <= dn_v_ff;
         for (int j = 0; j < NQ; j++) begin
            dv_v_ff[j+1] <= dv_v_ff[j];
         end
      end
   end

   // Sign, saturation and the zero-denominator case.
   awu_pkg::rsp_type res_in;
   logic [NQ-1:0]    q;

   assign q = dv_q_ff[NQ];

   always_comb begin
      res_in.element_tag = dv_tag_ff[NQ];
      res_in.overflowed  = 1'b0;
      if (dv_zero_ff[NQ]) begin
         res_in.delta_weight = 32'sd0;
      end else if (dv_neg_ff[NQ]) begin
         if (dv_big_ff[NQ] || q > NQ'(awu_pkg::SAT_POS)) begin
            res_in.delta_weight = awu_pkg::SAT_POS;
            res_in.overflowed   = 1'b1;
         end else begin
            res_in.delta_weight = q[31:0];
         end
      end else begin
         if (dv_big_ff[NQ] || q > NQ'(awu_pkg::SAT_NEG)) begin
            res_in.delta_weight = awu_pkg::SAT_NEG;
            res_in.overflowed   = 1'b1;
         end else begin
            res_in.delta_weight = -q[31:0];
         end
      end
   end

   // Two-entry output buffer keeps the pipeline moving while a beat waits.
   awu_pkg::rsp_type ob0_ff, ob1_ff;

   assign push      = adv && dv_v_ff[NQ];
   assign pop       = rsp_valid && rsp_ready;
   assign ob_cnt_in = ob_cnt_ff + 2'(push) - 2'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         ob_cnt_ff <= 2'd0;
      end else begin
         ob_cnt_ff <= ob_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push && pop) begin
         if (ob_cnt_ff == 2'd1) begin
            ob0_ff <= res_in;
         end else begin
            ob0_ff <= ob1_ff;
            ob1_ff <= res_in;
         end
      end else if (push) begin
         if (ob_cnt_ff == 2'd0) begin
            ob0_ff <= res_in;
         end else begin
            ob1_ff <= res_in;
         end
      end else if (pop) begin
         ob0_ff <= ob1_ff;
      end
   end

   assign rsp_valid = (ob_cnt_ff != 2'd0);
   assign rsp_data  = ob0_ff;

endmodule

// ----- hdl/awu_checker.sv -----
module awu_checker (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input awu_pkg::rsp_type rsp_data
);

`include "amsgrad_weight_update_core_assert.svh"

   logic sat_value;

   assign sat_value = (rsp_data.delta_weight == awu_pkg::SAT_POS)
                   || (rsp_data.delta_weight == awu_pkg::SAT_NEG);

   // A result beat that is held off stays offered and unchanged.
   `AWU_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid)
   `AWU_ASSERT(a_rsp_stable, rsp_valid && !rsp_ready |=> $stable(rsp_data))

   // An overflow flag only ever accompanies a saturated value.
   `AWU_ASSERT(a_ovf_sat, rsp_valid && rsp_data.overflowed |-> sat_value)

   // Reset empties the output buffer.
   `AWU_ASSERT_ALWAYS(a_reset_idle, reset |=> !rsp_valid)

endmodule

bind amsgrad_weight_update_core awu_checker u_awu_checker (.*);
